FILE: design/rad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_pkg - shared types and constants for the RLE alpha map decoder
// Frame size, field widths, phase and error codes, and the structs that
// pass between the decode core and the result queue.
// ----------------------------------------------------------------------------
package rad_pkg;

    // Decoded bytes in one frame (128 .. 4096)
    localparam int DECODED_BYTES = 4096;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 7;
    localparam int RUN_POS_W = 12;
    localparam int ERR_W     = 3;
    // Position counter must hold DECODED_BYTES itself
    localparam int POS_W     = $clog2(DECODED_BYTES + 1);
    localparam int SUM_W     = POS_W + 1;

    localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h7F;
    localparam int                FILL_BIT   = 7;

    typedef enum logic [2:0] {
        PH_CTRL = 3'b001,
        PH_FILL = 3'b010,
        PH_LIT  = 3'b100
    } phase_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 3'd0,
        ERR_TRUNC = 3'd1,
        ERR_ZERO  = 3'd2,
        ERR_OVER  = 3'd3,
        ERR_TFILL = 3'd4,
        ERR_TLIT  = 3'd5
    } err_code_t;

    typedef struct packed {
        logic                 run_valid;
        logic [RUN_POS_W-1:0] run_position;
        logic [BYTE_W-1:0]    run_value;
        logic [COUNT_W-1:0]   run_length;
        logic                 frame_done;
        err_code_t            error_code;
    } rad_result_t;

    typedef struct packed {
        logic        valid;
        rad_result_t result;
    } rad_push_t;

    typedef struct packed {
        logic space;
    } rad_queue_status_t;

endpackage

FILE: design/rad_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_if - stream channels of the RLE alpha map decoder
// Compressed byte channel in and decoded run channel out, valid/ready.
// ----------------------------------------------------------------------------
interface rad_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       frame_start;
    logic       last_byte;

    modport source (output valid, output stream_byte, output frame_start,
                    output last_byte, input ready);
    modport sink   (input valid, input stream_byte, input frame_start,
                    input last_byte, output ready);
endinterface

interface rad_out_if;
    logic        valid;
    logic        ready;
    logic        run_valid;
    logic [11:0] run_position;
    logic [7:0]  run_value;
    logic [6:0]  run_length;
    logic        frame_done;
    logic [2:0]  error_code;

    modport source (output valid, output run_valid, output run_position,
                    output run_value, output run_length, output frame_done,
                    output error_code, input ready);
    modport sink   (input valid, input run_valid, input run_position,
                    input run_value, input run_length, input frame_done,
                    input error_code, output ready);
endinterface

FILE: design/rad_decode_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_decode_core - per-byte decode step
// Holds the frame state and turns each accepted byte into at most one run.
// ----------------------------------------------------------------------------
module rad_decode_core (
    input  logic                       clk,
    input  logic                       rst_n,
    rad_in_if.sink                     in_ch,
    input  rad_pkg::rad_queue_status_t q_status,
    output rad_pkg::rad_push_t         push
);
    import rad_pkg::*;

    phase_t              phase_reg,    phase_next;
    logic [COUNT_W-1:0]  remain_reg,   remain_next;
    logic [COUNT_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic [POS_W-1:0]    pos_reg,      pos_next;
    logic                finished_reg, finished_next;

    phase_t              eff_phase;
    logic [COUNT_W-1:0]  eff_remain;
    logic [COUNT_W-1:0]  eff_fill_cnt;
    logic [POS_W-1:0]    eff_pos;
    logic                eff_finished;

    logic                in_fire;
    logic                start;
    logic                last;
    logic [BYTE_W-1:0]   b;
    logic [COUNT_W-1:0]  count;
    logic                fill;
    logic [POS_W-1:0]    pos_fill;
    logic [POS_W-1:0]    pos_inc;
    logic [COUNT_W-1:0]  remain_dec;
    logic [SUM_W-1:0]    pos_span;
    logic                done;

    assign in_ch.ready = q_status.space;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign start       = in_fire && in_ch.frame_start;
    assign last        = in_ch.last_byte;
    assign b           = in_ch.stream_byte;
    assign count       = COUNT_W'(b & COUNT_MASK);
    assign fill        = b[FILL_BIT];

    // frame start clears the state before this byte is decoded
    assign eff_phase    = start ? PH_CTRL : phase_reg;
    assign eff_remain   = start ? '0 : remain_reg;
    assign eff_fill_cnt = start ? '0 : fill_cnt_reg;
    assign eff_pos      = start ? '0 : pos_reg;
    assign eff_finished = start ? 1'b0 : finished_reg;

    assign pos_fill   = eff_pos + POS_W'(eff_fill_cnt);
    assign pos_inc    = eff_pos + POS_W'(1);
    assign remain_dec = eff_remain - COUNT_W'(1);
    assign pos_span   = SUM_W'(eff_pos) + SUM_W'(count);

    always_comb
    begin
        phase_next    = eff_phase;
        remain_next   = eff_remain;
        fill_cnt_next = eff_fill_cnt;
        pos_next      = eff_pos;
        finished_next = eff_finished;
        push          = '0;
        push.result.error_code = ERR_OK;
        done          = 1'b0;

        if (in_fire && !eff_finished)
        begin
            case (eff_phase)
                PH_FILL:
                begin
                    push.valid                = 1'b1;
                    push.result.run_valid     = 1'b1;
                    push.result.run_position  = RUN_POS_W'(eff_pos);
                    push.result.run_value     = b;
                    push.result.run_length    = eff_fill_cnt;
                    pos_next                  = pos_fill;
                    phase_next                = PH_CTRL;
                    fill_cnt_next             = '0;
                    if (pos_fill >= POS_W'(DECODED_BYTES))
                    begin
                        done = 1'b1;
                        push.result.error_code = ERR_OK;
                    end
                    else if (last)
                    begin
                        done = 1'b1;
                        push.result.error_code = ERR_TRUNC;
                    end
                end
                PH_LIT:
                begin
                    push.valid                = 1'b1;
                    push.result.run_valid     = 1'b1;
                    push.result.run_position  = RUN_POS_W'(eff_pos);
                    push.result.run_value     = b;
                    push.result.run_length    = COUNT_W'(1);
                    pos_next                  = pos_inc;
                    remain_next               = remain_dec;
                    if (remain_dec == '0)
                    begin
                        phase_next = PH_CTRL;
                        if (pos_inc >= POS_W'(DECODED_BYTES))
                        begin
                            done = 1'b1;
                            push.result.error_code = ERR_OK;
                        end
                        else if (last)
                        begin
                            done = 1'b1;
                            push.result.error_code = ERR_TRUNC;
                        end
                    end
                    else if (last)
                    begin
                        done = 1'b1;
                        push.result.error_code = ERR_TLIT;
                    end
                end
                default:
                begin
                    // control byte; zero count beats overrun beats truncation
                    if (count == '0)
                    begin
                        done       = 1'b1;
                        push.valid = 1'b1;
                        push.result.error_code = ERR_ZERO;
                    end
                    else if (pos_span > SUM_W'(DECODED_BYTES))
                    begin
                        done       = 1'b1;
                        push.valid = 1'b1;
                        push.result.error_code = ERR_OVER;
                    end
                    else if (last)
                    begin
                        done       = 1'b1;
                        push.valid = 1'b1;
                        push.result.error_code = fill ? ERR_TFILL : ERR_TLIT;
                    end
                    else if (fill)
                    begin
                        phase_next    = PH_FILL;
                        fill_cnt_next = count;
                    end
                    else
                    begin
                        phase_next  = PH_LIT;
                        remain_next = count;
                    end
                end
            endcase

            if (done)
            begin
                push.result.frame_done = 1'b1;
                finished_next = 1'b1;
                phase_next    = PH_CTRL;
                remain_next   = '0;
                fill_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CTRL;
            remain_reg   <= '0;
            fill_cnt_reg <= '0;
            pos_reg      <= '0;
            finished_reg <= 1'b1;
        end
        else
        begin
            phase_reg    <= phase_next;
            remain_reg   <= remain_next;
            fill_cnt_reg <= fill_cnt_next;
            pos_reg      <= pos_next;
            finished_reg <= finished_next;
        end
    end

endmodule

FILE: design/rad_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_result_queue - two-entry result buffer
// Registers decoded runs and lets the decoder keep going while one waits.
// ----------------------------------------------------------------------------
module rad_result_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rad_pkg::rad_push_t         push,
    output rad_pkg::rad_queue_status_t q_status,
    rad_out_if.source                  out_ch
);
    import rad_pkg::*;

    rad_result_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;
    logic        pop;
    rad_result_t head;

    assign pop  = out_ch.valid && out_ch.ready;
    assign head = entry_reg[rd_ptr_reg];

    // registered full flag only: no path from out ready to in ready
    assign q_status.space = (count_reg != 2'd2);

    assign out_ch.valid        = (count_reg != 2'd0);
    assign out_ch.run_valid    = head.run_valid;
    assign out_ch.run_position = head.run_position;
    assign out_ch.run_value    = head.run_value;
    assign out_ch.run_length   = head.run_length;
    assign out_ch.frame_done   = head.frame_done;
    assign out_ch.error_code   = head.error_code;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push.valid) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/rle_alpha_map_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_alpha_map_decoder - streaming run-length decoder for alpha map frames
//
// in_ch takes one compressed byte per transfer with frame_start and
// last_byte marks. A control byte (bit 7 fill flag, bits 6..0 count) is
// followed by one fill value or by count literal bytes. out_ch gives one
// transfer per decoded run (a fill run, or a single literal byte) carrying
// position, value and length, plus frame_done and error_code when the
// frame completes at DECODED_BYTES bytes or is aborted by an error.
// A control byte that ends the frame early gives a transfer with no run.
//
// Throughput: one byte per cycle while the result queue has space. A run
// goes to out_ch through the queue, behind any results already waiting. The
// decode step sits between the input handshake and a two-entry result
// queue; the queue's registered fill level sets in_ch.ready, so a stalled
// receiver stops input only once two results are waiting. While the queue
// is full every byte waits, including those that give no result.
//
// Reset empties the queue and leaves the decoder idle: bytes are ignored
// until one arrives with frame_start set.
// ----------------------------------------------------------------------------
module rle_alpha_map_decoder (
    input  logic      clk,
    input  logic      rst_n,
    rad_in_if.sink    in_ch,
    rad_out_if.source out_ch
);
    import rad_pkg::*;

    rad_push_t         push;
    rad_queue_status_t q_status;

    // byte decode and frame state
    rad_decode_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_status (q_status),
        .push     (push)
    );

    // result register stage towards the receiver
    rad_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .q_status (q_status),
        .out_ch   (out_ch)
    );

`ifndef NO_ASSERTIONS
    // a transfer without a run only ever reports an aborted frame
    a_norun_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.run_valid) |-> out_ch.frame_done)
        else $error("result without run does not end frame");

    // error code only accompanies a frame end
    a_err_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.frame_done) |-> (out_ch.error_code == ERR_OK))
        else $error("error code set on open frame");

    // run fields are zero when no run is carried
    a_norun_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.run_valid) |->
        (out_ch.run_length == '0 && out_ch.run_value == '0 &&
         out_ch.run_position == '0))
        else $error("run fields set without run");

    // input back-pressure only while results are waiting
    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid)
        else $error("input stalled with empty result queue");
`endif

endmodule
